>>> rtl/ips_patch_stream_decoder_defines.svh
// Assertion macros shared by the patch stream decoder RTL.
`ifndef IPS_PATCH_STREAM_DECODER_DEFINES_SVH
`define IPS_PATCH_STREAM_DECODER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define IPSD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define IPSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ipsd_pkg.sv
// Shared types and constants of the patch stream decoder.
`default_nettype none

package ipsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_FILL     = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_FAIL     = 2'd3;

    // Failure codes
    localparam logic [1:0] ERR_BAD_HEADER = 2'd0;
    localparam logic [1:0] ERR_OFFSET     = 2'd1;
    localparam logic [1:0] ERR_EARLY_END  = 2'd2;

    // Command queue between parser and emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // One parsed item: an optional main result and an optional trailing failure
    typedef struct packed {
        logic        main_valid;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] len;
        logic [7:0]  value;
        logic [1:0]  err;
        logic        tail_valid;
        logic [1:0]  tail_err;
    } cmd_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

>>> rtl/ipsd_queue.sv
// Short command queue that decouples the parser from the result emitter.
`default_nettype none

module ipsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enq,
    input  ipsd_pkg::cmd_t  enq_cmd,
    input  logic            deq,
    output ipsd_pkg::qstat_t qstat,
    output ipsd_pkg::cmd_t  head_cmd
);

    ipsd_pkg::cmd_t                    entry_reg [ipsd_pkg::QUEUE_DEPTH];
    logic [ipsd_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ipsd_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ipsd_pkg::QCNT_W-1:0]       count_reg;
    logic [ipsd_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [ipsd_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [ipsd_pkg::QCNT_W-1:0]       count_next;

    // Flags and head entry
    assign qstat.full  = (count_reg == ipsd_pkg::QCNT_W'(ipsd_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_cmd    = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ipsd_front.sv
// Byte parser: header match, record fields and command classification.
`default_nettype none

module ipsd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       patch_byte,
    input  logic             end_of_stream,
    input  logic [32:0]      usable_size,
    input  ipsd_pkg::qstat_t qstat,
    output logic             enq,
    output ipsd_pkg::cmd_t   enq_cmd
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OFFSET,
        PH_SIZE,
        PH_RUNLEN,
        PH_FILLBYTE,
        PH_DATA,
        PH_DONE
    } phase_t;

    // Header and end marker bytes
    function automatic logic [7:0] hdr_narrow(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h50;
            3'd1:    val = 8'h41;
            3'd2:    val = 8'h54;
            3'd3:    val = 8'h43;
            default: val = 8'h48;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] hdr_wide(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h49;
            3'd1:    val = 8'h50;
            3'd2:    val = 8'h53;
            3'd3:    val = 8'h33;
            default: val = 8'h32;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] eof_narrow(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h45;
            2'd1:    val = 8'h4F;
            default: val = 8'h46;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] eof_wide(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h45;
            2'd1:    val = 8'h45;
            2'd2:    val = 8'h4F;
            default: val = 8'h46;
        endcase
        return val;
    endfunction

    phase_t      phase_reg,  phase_next;
    logic        wide_reg,   wide_next;
    logic [1:0]  match_reg,  match_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [31:0] acc_reg,    acc_next;
    logic [31:0] addr_reg,   addr_next;
    logic [15:0] rem_reg,    rem_next;
    logic        eofc_reg,   eofc_next;

    logic           accept;
    logic [2:0]     hdr_idx;
    logic [1:0]     hdr_match;
    logic [1:0]     off_idx;
    logic [7:0]     mark;
    logic [31:0]    acc_shift;
    logic           eof_now;
    logic [2:0]     off_cnt;
    logic [15:0]    rem_shift;
    logic [15:0]    rem_dec;
    ipsd_pkg::cmd_t cmd;

    assign accept = push && !qstat.full;

    // Per-byte decode
    always_comb
    begin
        phase_next = phase_reg;
        wide_next  = wide_reg;
        match_next = match_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        eofc_next  = eofc_reg;
        cmd        = '0;

        hdr_idx   = (cnt_reg > 3'd4) ? 3'd4 : cnt_reg;
        hdr_match = match_reg & {patch_byte == hdr_wide(hdr_idx),
                                 patch_byte == hdr_narrow(hdr_idx)};
        off_idx   = cnt_reg[1:0];
        mark      = wide_reg ? eof_wide(off_idx)
                             : eof_narrow((off_idx == 2'd3) ? 2'd2 : off_idx);
        acc_shift = {acc_reg[23:0], patch_byte};
        eof_now   = eofc_reg && (patch_byte == mark);
        off_cnt   = {1'b0, off_idx} + 3'd1;
        rem_shift = {rem_reg[7:0], patch_byte};
        rem_dec   = rem_reg - 16'd1;

        case (phase_reg)
            PH_HEADER:
            begin
                match_next = hdr_match;
                if (hdr_match == 2'b00)
                begin
                    cmd.main_valid = 1'b1;
                    cmd.kind       = ipsd_pkg::KIND_FAIL;
                    cmd.err        = ipsd_pkg::ERR_BAD_HEADER;
                    phase_next     = PH_DONE;
                end
                else if (hdr_idx == 3'd4)
                begin
                    wide_next  = hdr_match[1];
                    phase_next = PH_OFFSET;
                    cnt_next   = '0;
                    acc_next   = '0;
                    eofc_next  = 1'b1;
                end
                else
                begin
                    cnt_next = hdr_idx + 3'd1;
                end
            end
            PH_OFFSET:
            begin
                acc_next  = acc_shift;
                eofc_next = eof_now;
                cnt_next  = off_cnt;
                if (off_cnt >= (wide_reg ? 3'd4 : 3'd3))
                begin
                    if (eof_now)
                    begin
                        cmd.main_valid = 1'b1;
                        cmd.kind       = ipsd_pkg::KIND_COMPLETE;
                        phase_next     = PH_DONE;
                    end
                    else if ({1'b0, acc_shift} > usable_size)
                    begin
                        cmd.main_valid = 1'b1;
                        cmd.kind       = ipsd_pkg::KIND_FAIL;
                        cmd.err        = ipsd_pkg::ERR_OFFSET;
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        addr_next  = acc_shift;
                        phase_next = PH_SIZE;
                        cnt_next   = '0;
                        rem_next   = '0;
                    end
                end
            end
            PH_SIZE, PH_RUNLEN:
            begin
                rem_next = rem_shift;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg >= 3'd1)
                begin
                    cnt_next = '0;
                    if (phase_reg == PH_RUNLEN)
                    begin
                        phase_next = PH_FILLBYTE;
                    end
                    else if (rem_shift == 16'd0)
                    begin
                        phase_next = PH_RUNLEN;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_FILLBYTE:
            begin
                cmd.main_valid = 1'b1;
                cmd.kind       = ipsd_pkg::KIND_FILL;
                cmd.addr       = addr_reg;
                cmd.len        = rem_reg;
                cmd.value      = patch_byte;
                phase_next     = PH_OFFSET;
                cnt_next       = '0;
                acc_next       = '0;
                eofc_next      = 1'b1;
            end
            PH_DATA:
            begin
                // Drop bytes that land outside the image
                if ({1'b0, addr_reg} < usable_size)
                begin
                    cmd.main_valid = 1'b1;
                    cmd.kind       = ipsd_pkg::KIND_WRITE;
                    cmd.addr       = addr_reg;
                    cmd.value      = patch_byte;
                end
                addr_next = (addr_reg == '1) ? addr_reg : addr_reg + 32'd1;
                rem_next  = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    phase_next = PH_OFFSET;
                    cnt_next   = '0;
                    acc_next   = '0;
                    eofc_next  = 1'b1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // End of file: flag an unfinished patch, then restart the parse
        if (end_of_stream)
        begin
            if (phase_next != PH_DONE)
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_err   = (phase_next == PH_HEADER) ? ipsd_pkg::ERR_BAD_HEADER
                                                           : ipsd_pkg::ERR_EARLY_END;
            end
            phase_next = PH_HEADER;
            wide_next  = 1'b0;
            match_next = 2'b11;
            cnt_next   = '0;
            acc_next   = '0;
            addr_next  = '0;
            rem_next   = '0;
            eofc_next  = 1'b0;
        end
    end

    assign enq     = accept && (cmd.main_valid || cmd.tail_valid);
    assign enq_cmd = cmd;

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            wide_reg  <= 1'b0;
            match_reg <= 2'b11;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            addr_reg  <= '0;
            rem_reg   <= '0;
            eofc_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            wide_reg  <= wide_next;
            match_reg <= match_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            eofc_reg  <= eofc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ipsd_back.sv
// Result emitter: expands queued commands, clips fills, drives the result register.
`default_nettype none

module ipsd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ipsd_pkg::qstat_t qstat,
    input  ipsd_pkg::cmd_t   head_cmd,
    input  logic [32:0]      usable_size,
    input  logic             pop,
    output logic             deq,
    output logic             empty,
    output logic [1:0]       kind,
    output logic [31:0]      target_address,
    output logic [15:0]      fill_length,
    output logic [7:0]       byte_value,
    output logic [1:0]       error_code,
    output logic             last_of_run
);

    logic        out_valid_reg, out_valid_next;
    logic        pend_reg,      pend_next;
    logic [1:0]  pend_err_reg,  pend_err_next;
    logic [1:0]  kind_reg,      kind_next;
    logic [31:0] addr_reg,      addr_next;
    logic [15:0] len_reg,       len_next;
    logic [7:0]  value_reg,     value_next;
    logic [1:0]  err_reg,       err_next;
    logic        last_reg,      last_next;

    logic        can_load;
    logic [32:0] fill_end;
    logic [32:0] fill_room;
    logic        fill_over;
    logic        fill_inside;
    logic [15:0] clip_len;

    // Clip a fill to the image
    assign fill_end    = {1'b0, head_cmd.addr} + {17'b0, head_cmd.len};
    assign fill_room   = usable_size - {1'b0, head_cmd.addr};
    assign fill_over   = fill_end > usable_size;
    assign fill_inside = {1'b0, head_cmd.addr} < usable_size;
    assign clip_len    = !fill_over  ? head_cmd.len :
                         fill_inside ? fill_room[15:0] : 16'd0;

    assign can_load = !out_valid_reg || pop;

    // Pick the next result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        pend_err_next  = pend_err_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        value_next     = value_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        deq            = 1'b0;
        if (can_load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                pend_next      = 1'b0;
                kind_next      = ipsd_pkg::KIND_FAIL;
                addr_next      = '0;
                len_next       = '0;
                value_next     = '0;
                err_next       = pend_err_reg;
                last_next      = 1'b1;
            end
            else if (!qstat.empty)
            begin
                deq            = 1'b1;
                out_valid_next = 1'b1;
                if (head_cmd.main_valid)
                begin
                    kind_next     = head_cmd.kind;
                    addr_next     = head_cmd.addr;
                    len_next      = (head_cmd.kind == ipsd_pkg::KIND_FILL) ? clip_len
                                                                           : head_cmd.len;
                    value_next    = head_cmd.value;
                    err_next      = head_cmd.err;
                    last_next     = !head_cmd.tail_valid;
                    pend_next     = head_cmd.tail_valid;
                    pend_err_next = head_cmd.tail_err;
                end
                else
                begin
                    kind_next  = ipsd_pkg::KIND_FAIL;
                    addr_next  = '0;
                    len_next   = '0;
                    value_next = '0;
                    err_next   = head_cmd.tail_err;
                    last_next  = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        pend_err_reg <= pend_err_next;
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        value_reg    <= value_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
    end

    assign empty          = !out_valid_reg;
    assign kind           = kind_reg;
    assign target_address = addr_reg;
    assign fill_length    = len_reg;
    assign byte_value     = value_reg;
    assign error_code     = err_reg;
    assign last_of_run    = last_reg;

endmodule

`default_nettype wire

>>> rtl/ips_patch_stream_decoder.sv
// Top level of the patch stream decoder: config register, parser, queue, emitter.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------------
//  input     push / full          patch_byte, end_of_stream
//  result    empty / pop          kind, target_address, fill_length, byte_value,
//                                 error_code, last_of_run
//  config    image_size_we        image_size_wdata
//
//  The parser takes one byte per cycle while its four-entry command queue has room.
//  The emitter sends one result per cycle while the receiver pops; a byte that yields
//  two results holds the emitter for both, so the queue absorbs such bursts.
//  A result passes through the command queue and then the result register on its way
//  to the result ports, and waits in the queue while the result register is busy.
//  Reset clears the parse state, the queue and the result valid flag; image_size is 0.
`default_nettype none
`include "ips_patch_stream_decoder_defines.svh"

module ips_patch_stream_decoder #(
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  patch_byte,
    input  logic        end_of_stream,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] target_address,
    output logic [15:0] fill_length,
    output logic [7:0]  byte_value,
    output logic [1:0]  error_code,
    output logic        last_of_run,
    input  logic        image_size_we,
    input  logic [31:0] image_size_wdata
);

    localparam logic [32:0] ADDR_LIMIT = 33'd1 << ADDR_BITS;

    logic [32:0]      usable_size_reg;
    logic [32:0]      usable_size_next;
    logic             enq;
    logic             deq;
    ipsd_pkg::cmd_t   enq_cmd;
    ipsd_pkg::cmd_t   head_cmd;
    ipsd_pkg::qstat_t qstat;

    // Store the image size already limited to the address space
    assign usable_size_next = ({1'b0, image_size_wdata} < ADDR_LIMIT) ?
                              {1'b0, image_size_wdata} : ADDR_LIMIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_size_reg <= '0;
        end
        else if (image_size_we)
        begin
            usable_size_reg <= usable_size_next;
        end
    end

    assign full = qstat.full;

    ipsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .patch_byte    (patch_byte),
        .end_of_stream (end_of_stream),
        .usable_size   (usable_size_reg),
        .qstat         (qstat),
        .enq           (enq),
        .enq_cmd       (enq_cmd)
    );

    ipsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_cmd  (enq_cmd),
        .deq      (deq),
        .qstat    (qstat),
        .head_cmd (head_cmd)
    );

    ipsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .head_cmd       (head_cmd),
        .usable_size    (usable_size_reg),
        .pop            (pop),
        .deq            (deq),
        .empty          (empty),
        .kind           (kind),
        .target_address (target_address),
        .fill_length    (fill_length),
        .byte_value     (byte_value),
        .error_code     (error_code),
        .last_of_run    (last_of_run)
    );

    // Terminal results always close their byte
    `IPSD_ASSERT_IMPLY(a_terminal_last, !empty && (kind == ipsd_pkg::KIND_COMPLETE || kind == ipsd_pkg::KIND_FAIL), last_of_run, "terminal result without last_of_run")
    // A result that is not last is followed at once by its trailing failure
    `IPSD_ASSERT_NEXT(a_pair_follows, !empty && pop && !last_of_run, !empty && kind == ipsd_pkg::KIND_FAIL && last_of_run, "companion failure missing")
    // Writes stay inside the image
    `IPSD_ASSERT_IMPLY(a_write_inside, !empty && kind == ipsd_pkg::KIND_WRITE, 33'(target_address) < usable_size_reg, "write outside image")
    // Fills are clipped to the image
    `IPSD_ASSERT_IMPLY(a_fill_clipped, !empty && kind == ipsd_pkg::KIND_FILL, (33'(target_address) + 33'(fill_length) <= usable_size_reg) || (fill_length == 16'd0), "fill not clipped")

endmodule

`default_nettype wire

>>> bench/tb_ips_patch_stream_decoder.sv
// Self-checking testbench for the patch stream decoder: directed patches, then random patch files.
`default_nettype none

module tb_ips_patch_stream_decoder;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 1130;

    localparam logic [39:0] HDR_PATCH = 40'h50_41_54_43_48;
    localparam logic [39:0] HDR_IPS32 = 40'h49_50_53_33_32;
    localparam logic [23:0] EOF_PATCH = 24'h45_4F_46;
    localparam logic [31:0] EOF_IPS32 = 32'h45_45_4F_46;
    localparam logic [1:0]  NO_ERROR  = 2'd0;

    typedef enum logic [2:0] {
        AT_HEADER,
        AT_OFFSET,
        AT_SIZE,
        AT_RUN_LENGTH,
        AT_FILL_VALUE,
        AT_DATA,
        AT_DONE
    } parse_step_e;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] len;
        logic [7:0]  value;
        logic [1:0]  err;
        logic        last;
    } decoder_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  patch_byte = 8'd0;
    logic        end_of_stream = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [31:0] target_address;
    logic [15:0] fill_length;
    logic [7:0]  byte_value;
    logic [1:0]  error_code;
    logic        last_of_run;
    logic        image_size_we = 1'b0;
    logic [31:0] image_size_wdata = 32'd0;

    // Predictor state
    parse_step_e step;
    logic        is_ips32;
    logic [1:0]  hdr_alive;
    logic [2:0]  byte_idx;
    logic [31:0] offset_acc;
    logic [31:0] wr_addr;
    logic [15:0] bytes_left;
    logic        maybe_end;
    logic [31:0] image_limit;

    decoder_result_t pending_results [$];
    decoder_result_t held_result;
    logic            have_held;

    logic [7:0] file_bytes [$];
    int         bytes_sent = 0;
    int         burst_left = 0;
    logic       calm = 1'b0;
    int         fail_count = 0;
    int         stalled_cycles = 0;

    rx_mode_e   pop_mode = RX_STREAM;
    int         pop_mode_left = 0;
    logic [4:0] pop_tick = 5'd0;

    ips_patch_stream_decoder #(.ADDR_BITS(32)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .patch_byte       (patch_byte),
        .end_of_stream    (end_of_stream),
        .empty            (empty),
        .pop              (pop),
        .kind             (kind),
        .target_address   (target_address),
        .fill_length      (fill_length),
        .byte_value       (byte_value),
        .error_code       (error_code),
        .last_of_run      (last_of_run),
        .image_size_we    (image_size_we),
        .image_size_wdata (image_size_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Append one expected result at the tail of the queue
    task automatic enqueue_result(input decoder_result_t r);
        pending_results = {pending_results, r};
    endtask

    // Append one byte to the file under construction
    task automatic append_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    // ---------------------------------------------------------------- predictor

    task automatic restart_parse();
        step       = AT_HEADER;
        is_ips32   = 1'b0;
        hdr_alive  = 2'b11;
        byte_idx   = 3'd0;
        offset_acc = 32'd0;
        wr_addr    = 32'd0;
        bytes_left = 16'd0;
        maybe_end  = 1'b0;
    endtask

    task automatic begin_offset();
        step       = AT_OFFSET;
        byte_idx   = 3'd0;
        offset_acc = 32'd0;
        maybe_end  = 1'b1;
    endtask

    // Hold back the newest result so the last one of a byte can be flagged
    task automatic add_result(input logic [1:0] kind_i, input logic [31:0] addr_i,
                              input logic [15:0] len_i, input logic [7:0] val_i,
                              input logic [1:0] err_i);
        if (have_held)
            enqueue_result(held_result);
        held_result = '{kind_i, addr_i, len_i, val_i, err_i, 1'b0};
        have_held = 1'b1;
    endtask

    task automatic decode_patch_byte(input logic [7:0] b, input logic eos);
        logic [2:0]  k;
        logic [7:0]  mark;
        logic [32:0] run_end;
        logic [31:0] clipped;
        have_held = 1'b0;
        case (step)
            AT_HEADER:
            begin
                k = (byte_idx > 3'd4) ? 3'd4 : byte_idx;
                if (b != HDR_PATCH[39 - 8*k -: 8])
                    hdr_alive[0] = 1'b0;
                if (b != HDR_IPS32[39 - 8*k -: 8])
                    hdr_alive[1] = 1'b0;
                if (hdr_alive == 2'b00)
                begin
                    add_result(ipsd_pkg::KIND_FAIL, 32'd0, 16'd0, 8'd0,
                               ipsd_pkg::ERR_BAD_HEADER);
                    step = AT_DONE;
                end
                else if (k == 3'd4)
                begin
                    is_ips32 = hdr_alive[1];
                    begin_offset();
                end
                else
                    byte_idx = k + 3'd1;
            end
            AT_OFFSET:
            begin
                k = {1'b0, byte_idx[1:0]};
                if (is_ips32)
                    mark = EOF_IPS32[31 - 8*k -: 8];
                else if (k < 3'd3)
                    mark = EOF_PATCH[23 - 8*k -: 8];
                else
                    mark = EOF_PATCH[7:0];
                offset_acc = {offset_acc[23:0], b};
                if (b != mark)
                    maybe_end = 1'b0;
                byte_idx = k + 3'd1;
                if (byte_idx >= (is_ips32 ? 3'd4 : 3'd3))
                begin
                    if (maybe_end)
                    begin
                        add_result(ipsd_pkg::KIND_COMPLETE, 32'd0, 16'd0, 8'd0, NO_ERROR);
                        step = AT_DONE;
                    end
                    else if (offset_acc > image_limit)
                    begin
                        add_result(ipsd_pkg::KIND_FAIL, 32'd0, 16'd0, 8'd0,
                                   ipsd_pkg::ERR_OFFSET);
                        step = AT_DONE;
                    end
                    else
                    begin
                        wr_addr    = offset_acc;
                        step       = AT_SIZE;
                        byte_idx   = 3'd0;
                        bytes_left = 16'd0;
                    end
                end
            end
            AT_SIZE, AT_RUN_LENGTH:
            begin
                bytes_left = {bytes_left[7:0], b};
                byte_idx = byte_idx + 3'd1;
                if (byte_idx >= 3'd2)
                begin
                    byte_idx = 3'd0;
                    if (step == AT_RUN_LENGTH)
                        step = AT_FILL_VALUE;
                    else if (bytes_left == 16'd0)
                        step = AT_RUN_LENGTH;
                    else
                        step = AT_DATA;
                end
            end
            AT_FILL_VALUE:
            begin
                // Cut the run at the end of the image, down to zero if it starts at or past it
                run_end = {1'b0, wr_addr} + {17'd0, bytes_left};
                if (run_end > {1'b0, image_limit})
                    clipped = (wr_addr < image_limit) ? image_limit - wr_addr : 32'd0;
                else
                    clipped = {16'd0, bytes_left};
                add_result(ipsd_pkg::KIND_FILL, wr_addr, clipped[15:0], b, NO_ERROR);
                begin_offset();
            end
            AT_DATA:
            begin
                // Drop bytes beyond the image; the address saturates at all ones
                if (wr_addr < image_limit)
                    add_result(ipsd_pkg::KIND_WRITE, wr_addr, 16'd0, b, NO_ERROR);
                if (wr_addr != 32'hFFFF_FFFF)
                    wr_addr = wr_addr + 32'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    begin_offset();
            end
            default:
                step = AT_DONE;
        endcase
        if (eos)
        begin
            if (step != AT_DONE)
                add_result(ipsd_pkg::KIND_FAIL, 32'd0, 16'd0, 8'd0,
                           (step == AT_HEADER) ? ipsd_pkg::ERR_BAD_HEADER
                                               : ipsd_pkg::ERR_EARLY_END);
            restart_parse();
        end
        if (have_held)
        begin
            held_result.last = 1'b1;
            enqueue_result(held_result);
        end
    endtask

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        // Open a new burst after a random gap, none while calm
        if (burst_left == 0)
        begin
            gap = calm ? 0 : $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        push          <= 1'b1;
        patch_byte    <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (full);
        decode_patch_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic send_file();
        calm = ($urandom_range(0, 4) == 0);
        foreach (file_bytes[k])
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // Hold the sender until every expected result has come, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_image_size(input logic [31:0] value);
        @(negedge clk);
        image_size_we    <= 1'b1;
        image_size_wdata <= value;
        @(negedge clk);
        image_size_we <= 1'b0;
        image_limit = value;
    endtask

    // ---------------------------------------------------------------- patch building

    task automatic add_word(input logic [15:0] w);
        append_byte(w[15:8]);
        append_byte(w[7:0]);
    endtask

    task automatic add_header(input logic wide);
        logic [39:0] hdr;
        hdr = wide ? HDR_IPS32 : HDR_PATCH;
        for (int k = 0; k < 5; k++)
            append_byte(hdr[39 - 8*k -: 8]);
    endtask

    task automatic add_offset(input logic wide, input logic [31:0] a);
        if (wide)
            append_byte(a[31:24]);
        append_byte(a[23:16]);
        add_word(a[15:0]);
    endtask

    task automatic add_data_record(input logic wide, input logic [31:0] a, input int n);
        add_offset(wide, a);
        add_word(n[15:0]);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_fill_record(input logic wide, input logic [31:0] a,
                                   input logic [15:0] run, input logic [7:0] val);
        add_offset(wide, a);
        add_word(16'd0);
        add_word(run);
        append_byte(val);
    endtask

    task automatic add_eof(input logic wide);
        if (wide)
            for (int k = 0; k < 4; k++)
                append_byte(EOF_IPS32[31 - 8*k -: 8]);
        else
            for (int k = 0; k < 3; k++)
                append_byte(EOF_PATCH[23 - 8*k -: 8]);
    endtask

    // Mostly well-formed files with random records; some noise, bad headers,
    // offsets past the image and truncated files
    task automatic add_random_file(input logic [31:0] img);
        logic        wide;
        logic [31:0] top;
        logic [31:0] lim;
        logic [31:0] a;
        logic [15:0] run;
        int          shape;
        int          n;
        int          k;
        wide  = ($urandom_range(0, 1) == 1);
        lim   = wide ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
        top   = (img > lim) ? lim : img;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_header(wide);
            if (shape == 1)
            begin
                k = $urandom_range(0, 4);
                file_bytes[k] = file_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 3))
                    0: a = (top > 32'd8) ? top - $urandom_range(0, 8) : $urandom_range(0, top);
                    1: a = $urandom_range(0, (top > 32'd64) ? 64 : top);
                    default: a = $urandom_range(0, top);
                endcase
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: run = 16'd0;
                        1: run = 16'hFFFF;
                        default: run = $urandom_range(1, 300);
                    endcase
                    add_fill_record(wide, a, run, $urandom_range(0, 255));
                end
                else
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                    add_data_record(wide, a, n);
                end
            end
            if (shape == 2 && top < lim)
                add_offset(wide, $urandom_range(top + 32'd1, lim));
            add_eof(wide);
            repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
            if (shape == 3)
            begin
                n = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > n)
                    void'(file_bytes.pop_back());
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_bad_header();
        set_image_size(32'd16);
        append_byte(8'h00);
        send_file();
        file_bytes = '{8'h50, 8'h41, 8'h58};
        send_file();
        file_bytes = '{8'h49, 8'h50, 8'h53};
        send_file();
    endtask

    task automatic test_narrow_records();
        add_header(1'b0);
        add_data_record(1'b0, 32'd0, 2);
        add_fill_record(1'b0, 32'd15, 16'd5, 8'hA5);
        add_eof(1'b0);
        send_file();
    endtask

    // Offset equal to the image size, a fill clipped to zero, bytes after the end marker
    task automatic test_wide_records();
        wait_idle();
        set_image_size(32'h100);
        add_header(1'b1);
        add_data_record(1'b1, 32'h100, 1);
        add_fill_record(1'b1, 32'h100, 16'hFFFF, 8'h5A);
        add_eof(1'b1);
        append_byte(8'hFF);
        append_byte(8'h00);
        send_file();
    endtask

    task automatic test_offset_beyond();
        add_header(1'b0);
        add_offset(1'b0, 32'h101);
        append_byte(8'hFF);
        append_byte(8'h45);
        send_file();
    endtask

    // Stream ends inside a data record: the last byte writes and fails
    task automatic test_early_end();
        add_header(1'b0);
        add_offset(1'b0, 32'd0);
        add_word(16'd4);
        append_byte(8'h81);
        append_byte(8'h7E);
        send_file();
    endtask

    task automatic test_address_limits();
        wait_idle();
        set_image_size(32'hFFFF_FFFF);
        add_header(1'b1);
        add_data_record(1'b1, 32'hFFFF_FFFE, 3);
        add_fill_record(1'b1, 32'hFFFF_FFF0, 16'h0020, 8'h00);
        add_eof(1'b1);
        send_file();
    endtask

    // Random files in phases; idle the block and change the image size between phases
    task automatic test_random_patches();
        logic [31:0] sizes [6];
        int          start;
        int          files;
        int          phase_idx;
        sizes[0]  = 32'd0;
        sizes[1]  = 32'hFFFF_FFFF;
        sizes[2]  = 32'h40;
        sizes[3]  = 32'h0100_0000;
        sizes[4]  = $urandom_range(1, 2000);
        sizes[5]  = $urandom;
        start     = bytes_sent;
        files     = 0;
        phase_idx = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (files % 8 == 0)
            begin
                wait_idle();
                set_image_size(sizes[phase_idx % 6]);
                phase_idx++;
            end
            add_random_file(image_limit);
            send_file();
            files++;
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Stall pattern of the receiver, switched at random
    always @(negedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode      <= rx_mode_e'($urandom_range(0, 3));
            pop_mode_left <= $urandom_range(40, 250);
        end
        else
            pop_mode_left <= pop_mode_left - 1;
        pop_tick <= pop_tick + 5'd1;
        case (pop_mode)
            RX_STREAM: pop <= 1'b1;
            RX_COIN:   pop <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:   pop <= (pop_tick >= 5'd28);
        endcase
    end

    // Compare each popped result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        decoder_result_t seen;
        decoder_result_t want;
        if (rst_n && pop && !empty)
        begin
            seen = '{kind, target_address, fill_length, byte_value, error_code, last_of_run};
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result kind %0d addr %h len %0d value %h",
                                       kind, target_address, fill_length, byte_value));
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                    note_failure($sformatf(
                        "expected kind %0d addr %h len %0d val %h err %0d last %0b, got %0d %h %0d %h %0d %0b",
                        want.kind, want.addr, want.len, want.value, want.err, want.last,
                        seen.kind, seen.addr, seen.len, seen.value, seen.err, seen.last));
            end
        end
    end

    // End the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        restart_parse();
        image_limit = 32'd0;
        have_held   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bad_header();
        test_narrow_records();
        test_wide_records();
        test_offset_beyond();
        test_early_end();
        test_address_limits();
        test_random_patches();
        wait_idle();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> ips_patch_stream_decoder.f
+incdir+rtl
rtl/ipsd_pkg.sv
rtl/ipsd_queue.sv
rtl/ipsd_front.sv
rtl/ipsd_back.sv
rtl/ips_patch_stream_decoder.sv
bench/tb_ips_patch_stream_decoder.sv
